// ===== hdl/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared constants and types of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 10;
  localparam int STORE_DEPTH = 62;
  localparam int MAX_LABEL   = 62;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // count must hold STORE_DEPTH itself
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int LABEL_CAP_I = (MAX_LABEL > STORE_DEPTH) ? STORE_DEPTH :
                               ((MAX_LABEL < 1) ? 1 : MAX_LABEL);

  localparam logic [CNT_W-1:0]  LABEL_CAP  = CNT_W'(LABEL_CAP_I);
  localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
  localparam logic [BYTE_W-1:0] SEPARATOR  = 8'h2E;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  // label store access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // load of the output register
  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic              label_too_long;
    logic              end_of_name;
  } out_load_t;

endpackage

// ===== hdl/dnle_in_if.sv =====
// ----------------------------------------------------------------------------
// dnle_in_if
// Host name byte channel: one character per word.
// ----------------------------------------------------------------------------
interface dnle_in_if;
  logic                         valid;
  logic                         ready;
  logic [dnle_pkg::BYTE_W-1:0]  name_byte;

  modport source (output valid, output name_byte, input ready);
  modport sink   (input valid, input name_byte, output ready);
endinterface

// ===== hdl/dnle_out_if.sv =====
// ----------------------------------------------------------------------------
// dnle_out_if
// Encoded name channel: one wire-format byte per word.
// ----------------------------------------------------------------------------
interface dnle_out_if;
  logic                         valid;
  logic                         ready;
  logic [dnle_pkg::BYTE_W-1:0]  out_byte;
  logic [dnle_pkg::POS_W-1:0]   position;
  logic                         label_too_long;
  logic                         end_of_name;

  modport source (output valid, output out_byte, output position,
                  output label_too_long, output end_of_name, input ready);
  modport sink   (input valid, input out_byte, input position,
                  input label_too_long, input end_of_name, output ready);
endinterface

// ===== hdl/dnle_label_store.sv =====
// ----------------------------------------------------------------------------
// dnle_label_store
// Label byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dnle_label_store (
  input  logic                        clk,
  input  dnle_pkg::ram_req_t          req,
  output logic [dnle_pkg::BYTE_W-1:0] rd_data
);
  import dnle_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/dnle_out_reg.sv =====
// ----------------------------------------------------------------------------
// dnle_out_reg
// Output register of the encoded byte stream; decouples the sequencer from
// downstream stalls.
// ----------------------------------------------------------------------------
module dnle_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  dnle_pkg::out_load_t ld,
  output logic                slot_free,
  dnle_out_if.source          out_word
);
  import dnle_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;
  logic              too_long_r;
  logic              eon_r;

  assign slot_free = !valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld.load) begin
      valid_r <= 1'b1;
    end else if (out_word.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      byte_r     <= ld.out_byte;
      pos_r      <= ld.position;
      too_long_r <= ld.label_too_long;
      eon_r      <= ld.end_of_name;
    end
  end

  assign out_word.valid          = valid_r;
  assign out_word.out_byte       = byte_r;
  assign out_word.position       = pos_r;
  assign out_word.label_too_long = too_long_r;
  assign out_word.end_of_name    = eon_r;

endmodule

// ===== hdl/dns_name_label_encoder_core.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Encodes a dotted host name, one byte per input word, into DNS wire-format
// labels. An ordinary character is written into the label memory. A dot or
// a zero byte starts a flush: the length byte, then each buffered character
// read from the single read port of the label memory, then the terminator
// after a zero byte; input is not taken during a flush, and output stalls
// stretch it. Characters beyond MAX_LABEL are dropped and flag the label.
// Output position saturates at 1023 and restarts after each name.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  dnle_in_if.sink    in_word,
  dnle_out_if.source out_word
);
  import dnle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              term_r, term_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  idx_next_cnt;
  logic [BYTE_W-1:0] rd_data;
  logic              slot_free;
  ram_req_t          ram_req;
  out_load_t         oload;

  dnle_label_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  dnle_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (oload),
    .slot_free (slot_free),
    .out_word  (out_word)
  );

  assign in_word.ready = (state_r == ST_IDLE);
  assign pos_inc       = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign idx_next_cnt  = CNT_W'(idx_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    term_nxt  = term_r;
    pos_nxt   = pos_r;
    ram_req   = '0;
    oload     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_word.valid) begin
          if (in_word.name_byte == SEPARATOR || in_word.name_byte == TERMINATOR) begin
            term_nxt  = (in_word.name_byte == TERMINATOR);
            state_nxt = ST_LEN;
          end else if (count_r < LABEL_CAP) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = ADDR_W'(count_r);
            ram_req.wdata = in_word.name_byte;
            count_nxt     = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          oload.load           = 1'b1;
          oload.out_byte       = BYTE_W'(count_r);
          oload.position       = pos_r;
          oload.label_too_long = ovf_r;
          pos_nxt              = pos_inc;
          if (count_r == '0) begin
            ovf_nxt   = 1'b0;
            state_nxt = term_r ? ST_TERM : ST_IDLE;
          end else begin
            // prefetch first character
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            idx_nxt       = '0;
            state_nxt     = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (slot_free) begin
          oload.load           = 1'b1;
          oload.out_byte       = rd_data;
          oload.position       = pos_r;
          oload.label_too_long = ovf_r;
          pos_nxt              = pos_inc;
          if (idx_next_cnt == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = term_r ? ST_TERM : ST_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_r + 1'b1;
            idx_nxt       = idx_r + 1'b1;
          end
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          oload.load        = 1'b1;
          oload.out_byte    = TERMINATOR;
          oload.position    = pos_r;
          oload.end_of_name = 1'b1;
          pos_nxt           = '0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      term_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      term_r  <= term_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // label fill and label readout never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("label store written and read in the same cycle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LABEL_CAP)
    else $error("label count beyond cap");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    oload.load |-> slot_free)
    else $error("output register overwritten while held");

  a_term_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (oload.load && oload.end_of_name) |=> (pos_r == '0 && state_r == ST_IDLE))
    else $error("position not restarted after terminator");

endmodule
